[rtl/circular_bus_panner_unit_defines.svh]
// Assertion macros for the circular bus panner unit.
// Used by the top level only; no other dependencies.
`ifndef CIRCULAR_BUS_PANNER_UNIT_DEFINES_SVH
`define CIRCULAR_BUS_PANNER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CBP_ASSERT(lbl, prop, msg)
`define CBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/cbp_pkg.sv]
// Package for the circular bus panner unit: widths, register indexes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbp_pkg;

  localparam int unsigned MaxBusesDef = 8;
  localparam int unsigned SampleW     = 24;
  localparam int unsigned FracW       = 16;
  localparam int unsigned CountW      = 4;
  localparam int unsigned IdxOutW     = 3;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned GainW       = FracW + 1;
  localparam int unsigned InDataW     = 2 * SampleW;
  localparam int unsigned OutDataW    = 56;

  localparam logic [GainW-1:0]  OneQ16      = 17'h10000;
  localparam logic [CountW-1:0] BusCountRst = 4'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAN    = 2'd0,
    REG_COUNT  = 2'd1,
    REG_SPREAD = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_DIST,
    ST_DIV,
    ST_STORE,
    ST_READY
  } seq_state_e;

endpackage

`default_nettype wire

[rtl/circular_bus_panner_unit.sv]
// Circular bus panner: splits one stereo pair into one gain-scaled pair per bus.
// Depends on cbp_pkg and circular_bus_panner_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_bus_panner_unit_defines.svh"

// Each accepted stereo pair yields n result pairs (n = active buses, 1..MAX_BUSES),
// bus 0 first, one per cycle while the master side does not stall, tlast on the final
// bus. A new pair is taken only as the last bus of the previous pair leaves the bus
// expander; results pass through the gain lookup, multiply and output registers. Bus
// gains are held in a small table filled by a bit-serial divider after reset and
// after every register write; during that fill the slave side is held off.
// Register writes are always taken.
module circular_bus_panner_unit #(
  parameter int unsigned MAX_BUSES = cbp_pkg::MaxBusesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cbp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [cbp_pkg::CfgDataW-1:0]  cfg_data_i,
  // slave stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [cbp_pkg::InDataW-1:0]   s_axis_tdata,  // left, right
  // master stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [cbp_pkg::OutDataW-1:0]       m_axis_tdata,  // bus_index, bus_left,
                                                             // bus_right, zero pad
  output logic                               m_axis_tlast   // last_bus
);
  import cbp_pkg::*;

  localparam int unsigned IW = (MAX_BUSES > 1) ? $clog2(MAX_BUSES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned NB = $clog2(MAX_BUSES + 1);
  localparam int unsigned AW = FracW + NB;
  localparam int unsigned NW = AW + FracW;
  localparam int unsigned KW = $clog2(NW);
  localparam int unsigned PW = SampleW + GainW + 1;

  // ---------------- registers ----------------
  logic [FracW-1:0]  pan_q, spread_q;
  logic [CountW-1:0] count_q;
  logic              cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q    <= '0;
      count_q  <= BusCountRst;
      spread_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PAN:    pan_q    <= cfg_data_i;
        REG_COUNT:  count_q  <= cfg_data_i[CountW-1:0];
        REG_SPREAD: spread_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [4:0]    cnt_ext, max_ext, n_ext;
  logic [NB-1:0] n_act;

  assign cnt_ext = 5'(count_q);
  assign max_ext = 5'(MAX_BUSES);
  assign n_ext   = (cnt_ext == 5'd0) ? 5'd1 : ((cnt_ext > max_ext) ? max_ext : cnt_ext);
  assign n_act   = NB'(n_ext);

  // ---------------- gain sequencer ----------------
  seq_state_e     state_q, state_d;
  logic [IW-1:0]  bidx_q;
  logic [KW-1:0]  step_q;
  logic [NW-1:0]  num_q, quo_q;
  logic [FracW:0] rem_q;
  logic [GainW-1:0] gain_tab_q [MAX_BUSES];

  logic seq_load, seq_step, seq_store, seq_ready, seq_last;

  assign seq_last = ((CW'(bidx_q) + 1'b1) == CW'(n_act));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_DIST:  state_d = ST_DIV;
      ST_DIV:   if (step_q == '0) state_d = ST_STORE;
      ST_STORE: state_d = seq_last ? ST_READY : ST_DIST;
      ST_READY: state_d = ST_READY;
      default:  state_d = ST_DIST;
    endcase
    if (cfg_wr) state_d = ST_DIST;
  end

  always_comb begin
    seq_load  = 1'b0;
    seq_step  = 1'b0;
    seq_store = 1'b0;
    seq_ready = 1'b0;
    case (state_q)
      ST_DIST:  seq_load  = 1'b1;
      ST_DIV:   seq_step  = 1'b1;
      ST_STORE: seq_store = 1'b1;
      ST_READY: seq_ready = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DIST;
      bidx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        bidx_q <= '0;
      end else if (seq_store && !seq_last) begin
        bidx_q <= bidx_q + 1'b1;
      end
    end
  end

  // circular distance, scaled by n * 2^16
  logic [AW-1:0] pos_a, pos_b, full, diff, wrap, arc_len;

  assign pos_a   = AW'(pan_q) * AW'(n_act);
  assign pos_b   = {AW'(bidx_q)} << FracW;
  assign full    = {AW'(n_act)} << FracW;
  assign diff    = (pos_a > pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);
  assign wrap    = full - diff;
  assign arc_len = (wrap < diff) ? wrap : diff;

  // restoring divide, one quotient bit per cycle
  logic [FracW+1:0] trial, denom;
  logic             fits;
  logic [GainW-1:0] ratio, gain_new;

  assign denom    = {1'b0, OneQ16} + (FracW + 2)'(spread_q);
  assign trial    = {rem_q, num_q[NW-1]};
  assign fits     = (trial >= denom);
  assign ratio    = (quo_q > NW'(OneQ16)) ? OneQ16 : quo_q[GainW-1:0];
  assign gain_new = OneQ16 - ratio;

  always_ff @(posedge clk_i) begin
    if (seq_load) begin
      num_q  <= {arc_len, {FracW{1'b0}}};
      quo_q  <= '0;
      rem_q  <= '0;
      step_q <= KW'(NW - 1);
    end else if (seq_step) begin
      num_q  <= {num_q[NW-2:0], 1'b0};
      quo_q  <= {quo_q[NW-2:0], fits};
      rem_q  <= fits ? (FracW + 1)'(trial - denom) : trial[FracW:0];
      step_q <= step_q - 1'b1;
    end
    if (seq_store) begin
      gain_tab_q[bidx_q] <= gain_new;
    end
  end

  // ---------------- sample pipeline ----------------
  logic                      v0_q, v1_q, v2_q, v3_q;
  logic                      rdy1, rdy2, rdy3, adv0, last0, in_acc;
  logic signed [SampleW-1:0] l0_q, r0_q, l1_q, r1_q;
  logic [IW-1:0]             i0_q, i1_q, i2_q, i3_q;
  logic                      t1_q, t2_q, t3_q;
  logic [GainW-1:0]          g1_q;
  logic signed [PW-1:0]      p2_l_q, p2_r_q;
  logic [SampleW-1:0]        o3_l_q, o3_r_q;

  assign rdy3  = !v3_q || m_axis_tready;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign adv0  = v0_q && rdy1;
  assign last0 = ((CW'(i0_q) + 1'b1) == CW'(n_act));

  assign s_axis_tready = seq_ready && (!v0_q || (rdy1 && last0));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      i0_q <= '0;
    end else begin
      if (in_acc) begin
        v0_q <= 1'b1;
        i0_q <= '0;
      end else if (adv0) begin
        if (last0) begin
          v0_q <= 1'b0;
        end else begin
          i0_q <= i0_q + 1'b1;
        end
      end
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      l0_q <= s_axis_tdata[SampleW-1:0];
      r0_q <= s_axis_tdata[2*SampleW-1:SampleW];
    end
    if (rdy1) begin
      l1_q <= l0_q;
      r1_q <= r0_q;
      i1_q <= i0_q;
      t1_q <= last0;
      g1_q <= gain_tab_q[i0_q];
    end
    if (rdy2) begin
      p2_l_q <= PW'(l1_q) * $signed({1'b0, g1_q});
      p2_r_q <= PW'(r1_q) * $signed({1'b0, g1_q});
      i2_q   <= i1_q;
      t2_q   <= t1_q;
    end
    if (rdy3) begin
      o3_l_q <= p2_l_q[FracW+SampleW-1:FracW];
      o3_r_q <= p2_r_q[FracW+SampleW-1:FracW];
      i3_q   <= i2_q;
      t3_q   <= t2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tlast  = t3_q;
  assign m_axis_tdata  = {{(OutDataW - IdxOutW - 2 * SampleW){1'b0}},
                          o3_r_q, o3_l_q, IdxOutW'(i3_q)};

  // ---------------- checks ----------------
  `CBP_ASSERT(a_in_only_ready, s_axis_tvalid && s_axis_tready |-> state_q == ST_READY,
              "request taken while gain table not ready")
  `CBP_ASSERT(a_cfg_holds_off, cfg_valid_i && cfg_ready_o |=> !s_axis_tready,
              "slave side open right after register write")
  `CBP_ASSERT(a_last_index, m_axis_tvalid && m_axis_tlast |-> (CW'(i3_q) + 1'b1) == CW'(n_act),
              "tlast on wrong bus")
  `CBP_ASSERT(a_gain_range, v1_q |-> g1_q <= OneQ16, "bus gain above unity")

endmodule

`default_nettype wire
